// ===== src/sdf_pkg.sv =====
package sdf_pkg;

    // store geometry
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DATA_W      = 32;

    // front queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_list;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     keep;
        logic                     overflow;
        logic                     end_out;
    } out_item_t;

    // head of the front queue as seen by the back end
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } queue_head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

// ===== src/sdf_ram.sv =====
module sdf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sdf_front.sv =====
module sdf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sdf_pkg::in_item_t    s_data,
    output sdf_pkg::queue_head_t q_head,
    input  logic                 q_pop
);

    sdf_pkg::in_item_t              slot_reg [sdf_pkg::QUEUE_DEPTH];
    logic [sdf_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [sdf_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [sdf_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                           push;
    logic                           pop;

    assign s_ready = (cnt_reg != sdf_pkg::QCNT_W'(sdf_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (cnt_reg != '0);

    assign q_head.valid = (cnt_reg != '0);
    assign q_head.item  = slot_reg[rd_ptr_reg];

    // pointer wrap at queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == sdf_pkg::QPTR_W'(sdf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == sdf_pkg::QPTR_W'(sdf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= sdf_pkg::QCNT_W'(sdf_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");

    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

// ===== src/sdf_back.sv =====
module sdf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdf_pkg::queue_head_t q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sdf_pkg::out_item_t   m_data
);

    sdf_pkg::back_state_t           state_reg, state_next;
    logic [sdf_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [sdf_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           found_reg, found_next;
    logic                           out_valid_reg, out_valid_next;
    sdf_pkg::out_item_t             out_reg, out_next;

    logic                           rd_en;
    logic [sdf_pkg::ADDR_W-1:0]     rd_addr;
    logic [sdf_pkg::DATA_W-1:0]     rd_data;
    logic                           wr_en;
    logic                           match;
    logic                           out_free;
    logic                           scan_done;
    logic                           store_full;

    sdf_ram #(
        .WIDTH (sdf_pkg::DATA_W),
        .DEPTH (sdf_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[sdf_pkg::ADDR_W-1:0]),
        .wr_data (q_head.item.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign match      = (rd_data == $unsigned(q_head.item.value));
    assign out_free   = !out_valid_reg || m_ready;
    assign scan_done  = (idx_reg == count_reg);
    assign store_full = (count_reg == sdf_pkg::CNT_W'(sdf_pkg::STORE_DEPTH));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sdf_pkg::ST_IDLE: begin
                if (q_head.valid) begin
                    state_next = (count_reg == '0) ? sdf_pkg::ST_FINISH : sdf_pkg::ST_SCAN;
                end
            end
            sdf_pkg::ST_SCAN: begin
                if (match || scan_done) begin
                    state_next = sdf_pkg::ST_FINISH;
                end
            end
            sdf_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = sdf_pkg::ST_IDLE;
                end
            end
            default: state_next = sdf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        q_pop          = 1'b0;
        idx_next       = idx_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            sdf_pkg::ST_IDLE: begin
                if (q_head.valid) begin
                    found_next = 1'b0;
                    if (count_reg != '0) begin
                        rd_en    = 1'b1;
                        idx_next = sdf_pkg::CNT_W'(1);
                    end
                end
            end
            sdf_pkg::ST_SCAN: begin
                // read data belongs to the address issued in the previous cycle
                if (match) begin
                    found_next = 1'b1;
                end else if (!scan_done) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg[sdf_pkg::ADDR_W-1:0];
                    idx_next = idx_reg + 1'b1;
                end
            end
            sdf_pkg::ST_FINISH: begin
                if (out_free) begin
                    q_pop              = 1'b1;
                    out_valid_next     = 1'b1;
                    out_next.value_out = q_head.item.value;
                    out_next.keep      = !found_reg;
                    out_next.overflow  = !found_reg && store_full;
                    out_next.end_out   = q_head.item.end_of_list;
                    wr_en              = !found_reg && !store_full;
                    if (q_head.item.end_of_list) begin
                        count_next = '0;
                    end else if (!found_reg && !store_full) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sdf_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        found_reg <= found_next;
        out_reg   <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sdf_pkg::CNT_W'(sdf_pkg::STORE_DEPTH))
        else $error("store count above depth");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sdf_pkg::ST_SCAN |-> (count_reg != '0 && idx_reg <= count_reg))
        else $error("scan over an empty store or past its fill");

    a_ovf_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.overflow) |-> m_data.keep)
        else $error("overflow flagged on a dropped value");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.item.end_of_list) |=> count_reg == '0)
        else $error("store not emptied after end of list");

endmodule

// ===== src/stream_duplicate_filter_core.sv =====
// channel | ports                       | payload            | role
// --------+-----------------------------+--------------------+----------------------------
// input   | s_valid, s_ready, s_data    | in_item_t          | list values with end mark
// result  | m_valid, m_ready, m_data    | out_item_t         | value, keep, overflow, end
//
// each transaction in the back end starts in idle, reads the n values stored so far in
// the current list (0 to 64), one store read per cycle, until a match or the fill is reached,
// and then finishes, waiting there while the result register is still held
// the store ram's single read port is why the scan reads one value at a time
// reset (aresetn low, synchronous) empties the store and the input queue
// a two-entry input queue and the result register let either side stall alone

module stream_duplicate_filter_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sdf_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sdf_pkg::out_item_t m_data
);

    // head of the input queue and the pop from the back end
    sdf_pkg::queue_head_t q_head;
    logic                 q_pop;

    // front: accepts transactions into a short queue
    sdf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    // back: scans the store, appends new values, registers the result
    sdf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== tb/tb_stream_duplicate_filter_core.sv =====
module tb_stream_duplicate_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    // random stimulus starts no new list once this many input transactions have gone in
    localparam int ITEM_TARGET = 950;
    // longest quiet stretch in a correct run: the tail wait, or one full
    // scan of the store plus the longest random stall on each side, so
    // this leaves a wide margin
    localparam int IDLE_LIMIT  = 2000;
    // a full scan of the store plus a little slack
    localparam int TAIL_CYCLES = sdf_pkg::STORE_DEPTH + 16;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    sdf_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    sdf_pkg::out_item_t m_data;

    stream_duplicate_filter_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // directed stimulus row: run > 1 sends value, value + 1, ... with the
    // end mark only on the last one; known rows carry their keep / overflow
    typedef struct {
        logic [sdf_pkg::DATA_W-1:0] value;
        logic                       eol;
        int                         run;
        bit                         known;
        logic                       keep;
        logic                       ovf;
    } dir_row_t;

    dir_row_t dir_rows [17] = '{
        '{32'h0000_0000, 1'b0, 1, 1'b1, 1'b1, 1'b0},  // first transaction after reset
        '{32'h0000_0000, 1'b0, 1, 1'b1, 1'b0, 1'b0},  // plain repeat
        '{32'h8000_0000, 1'b0, 1, 1'b1, 1'b1, 1'b0},  // most negative
        '{32'h7fff_ffff, 1'b0, 1, 1'b1, 1'b1, 1'b0},  // most positive
        '{32'hffff_ffff, 1'b0, 1, 1'b1, 1'b1, 1'b0},  // all ones
        '{32'h8000_0000, 1'b0, 1, 1'b1, 1'b0, 1'b0},  // repeat of an extreme
        '{32'hffff_ffff, 1'b1, 1, 1'b1, 1'b0, 1'b0},  // repeat that closes the list
        '{32'h0000_0000, 1'b1, 1, 1'b1, 1'b1, 1'b0},  // single-item list
        '{32'h0000_0000, 1'b1, 1, 1'b1, 1'b1, 1'b0},  // and again, store was emptied
        '{32'h0000_0100, 1'b0, sdf_pkg::STORE_DEPTH, 1'b0, 1'b0, 1'b0},  // fill the store
        '{32'h0000_0005, 1'b0, 1, 1'b1, 1'b1, 1'b1},  // new value, store full
        '{32'h0000_0005, 1'b0, 1, 1'b1, 1'b1, 1'b1},  // copy of a value never stored
        '{32'h0000_0100, 1'b0, 1, 1'b1, 1'b0, 1'b0},  // oldest stored entry
        '{32'(32'h100 + sdf_pkg::STORE_DEPTH - 1), 1'b0, 1, 1'b1, 1'b0, 1'b0},  // newest entry
        '{32'haaaa_aaaa, 1'b1, 1, 1'b1, 1'b1, 1'b1},  // full store on the last item
        '{32'h5555_5555, 1'b1, 1, 1'b1, 1'b1, 1'b0},  // store cleared after overflow
        '{32'h0000_0100, 1'b1, 1, 1'b1, 1'b1, 1'b0}   // old list's value is new here
    };

    // predictor state: distinct values of the current list
    logic [sdf_pkg::DATA_W-1:0] seen_vals [sdf_pkg::STORE_DEPTH];
    int                         seen_fill = 0;
    sdf_pkg::out_item_t         pending_res [$];

    int err_cnt     = 0;
    int n_sent      = 0;
    int n_lists     = 0;
    int n_kept      = 0;
    int n_dropped   = 0;
    int n_ovf       = 0;
    int n_results   = 0;
    int idle_cycles = 0;
    bit src_calm    = 1'b0;
    bit sink_calm   = 1'b0;

    function automatic sdf_pkg::out_item_t distinct_predict(input sdf_pkg::in_item_t it);
        sdf_pkg::out_item_t r;
        bit                 found;
        found = 1'b0;
        for (int i = 0; i < seen_fill; i++) begin
            if (seen_vals[i] == it.value) begin
                found = 1'b1;
            end
        end
        r.value_out = it.value;
        r.end_out   = it.end_of_list;
        r.keep      = !found;
        r.overflow  = 1'b0;
        if (!found) begin
            if (seen_fill < sdf_pkg::STORE_DEPTH) begin
                seen_vals[seen_fill] = it.value;
                seen_fill++;
            end else begin
                r.overflow = 1'b1;
            end
        end
        if (it.end_of_list) begin
            seen_fill = 0;
        end
        return r;
    endfunction

    // mix of extremes, small magnitudes and full-width random words
    function automatic logic [sdf_pkg::DATA_W-1:0] draw_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
            2: return 32'($urandom_range(0, 15));
            3: return -32'($urandom_range(1, 16));
            default: return $urandom();
        endcase
    endfunction

    task automatic report(input string what, input logic [sdf_pkg::DATA_W-1:0] got,
                          input logic [sdf_pkg::DATA_W-1:0] want);
        $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
        err_cnt++;
    endtask

    // one input transaction; entered and left at a falling edge, valid stays
    // high on return so a back-to-back transaction needs no toggle
    task automatic push_value(input logic [sdf_pkg::DATA_W-1:0] v, input logic eol,
                              input bit known, input logic k, input logic ov);
        sdf_pkg::in_item_t  it;
        sdf_pkg::out_item_t want;
        int                 gap;
        it.value       = v;
        it.end_of_list = eol;
        gap = src_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        want = distinct_predict(it);
        if (known) begin
            want.keep     = k;
            want.overflow = ov;
        end
        pending_res.push_back(want);
        n_sent++;
        if (want.keep) n_kept++; else n_dropped++;
        if (want.overflow) n_ovf++;
        if (eol) n_lists++;
        @(negedge aclk);
    endtask

    // sender holds off until every pending result has come out
    task automatic drain_wait();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_res.size() != 0);
    endtask

    // result side: random stall before each transaction, none in calm stretches
    initial begin : sink
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            gap = sink_calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // compare each result transaction with the oldest pending one
    always @(posedge aclk) begin : result_check
        sdf_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_res.size() == 0) begin
                report("result with nothing pending, value", m_data.value_out, '0);
            end else begin
                want = pending_res.pop_front();
                if (m_data.value_out !== want.value_out)
                    report("value_out", m_data.value_out, want.value_out);
                if (m_data.keep !== want.keep)
                    report("keep", 32'(m_data.keep), 32'(want.keep));
                if (m_data.overflow !== want.overflow)
                    report("overflow", 32'(m_data.overflow), 32'(want.overflow));
                if (m_data.end_out !== want.end_out)
                    report("end_out", 32'(m_data.end_out), 32'(want.end_out));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t                   row;
        logic [sdf_pkg::DATA_W-1:0] pool [$];
        int                         len;
        int                         pool_sz;
        logic                       eol;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows, the fill row predicted, the rest read off at a glance
        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (int k = 0; k < row.run; k++) begin
                eol = (k == row.run - 1) ? row.eol : 1'b0;
                push_value(row.value + k, eol, row.known && row.run == 1, row.keep, row.ovf);
            end
        end
        drain_wait();

        // random lists: mostly short with heavy repeats, a few long enough
        // to run past a full store
        while (n_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 8);
                7, 8:                len = $urandom_range(9, 40);
                default: len = $urandom_range(sdf_pkg::STORE_DEPTH - 4,
                                              sdf_pkg::STORE_DEPTH + 24);
            endcase
            pool_sz = $urandom_range(0, 1) ? len : $urandom_range(1, len);
            pool.delete();
            repeat (pool_sz) pool.push_back(draw_word());
            src_calm  = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                drain_wait();
            end
            for (int k = 0; k < len; k++) begin
                push_value(pool[$urandom_range(0, pool_sz - 1)], k == len - 1,
                           1'b0, 1'b0, 1'b0);
            end
        end
        s_valid <= 1'b0;

        while (pending_res.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("sent %0d transactions in %0d lists: %0d kept, %0d dropped, %0d past a full store",
                 n_sent, n_lists, n_kept, n_dropped, n_ovf);
        $display("checked %0d results, %0d mismatches", n_results, err_cnt);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
